>>> design/tpbd_pkg.sv
// Package for the tape pulse to byte block decoder.
// Holds field widths, register indexes, reset values, pulse classes and result codes.
// No dependencies.
package tpbd_pkg;

  // Field and register widths
  localparam int unsigned TickBitsDef = 40;
  localparam int unsigned DivW        = 10;
  localparam int unsigned UsW         = 16;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned KindW       = 2;
  localparam int unsigned ValueW      = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgTicksPerUs = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgShortMin   = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgShortMax   = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgLongLimit  = 4'd3;

  // Register reset values
  localparam logic [DivW-1:0] TicksPerUsRst = 10'd16;
  localparam logic [UsW-1:0]  ShortMinRst   = 16'd150;
  localparam logic [UsW-1:0]  ShortMaxRst   = 16'd360;
  localparam logic [UsW-1:0]  LongLimitRst  = 16'd550;

  localparam logic [7:0]      ByteMask      = 8'hff;
  localparam logic [UsW-1:0]  CountMax      = 16'hffff;

  // Pulse classes
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_LONG  = 2'd2,
    CLS_PAUSE = 2'd3
  } pulse_cls_e;

  // Input actions
  localparam logic ActPulse = 1'b0;
  localparam logic ActEnd   = 1'b1;

  // Result kinds
  localparam logic [KindW-1:0] KindByte  = 2'd0;
  localparam logic [KindW-1:0] KindBlock = 2'd1;
  localparam logic [KindW-1:0] KindEmpty = 2'd2;

  // Data pulse phases
  localparam logic [1:0] PhaseNone = 2'd0;
  localparam logic [1:0] PhaseOdd  = 2'd1;
  localparam logic [1:0] PhaseEven = 2'd2;

  // Good wave run saturates here
  localparam logic [1:0] RunFull = 2'd2;

endpackage

>>> design/tape_pulse_to_byte_block_decoder.sv
// Tape pulse decoder top level: pulse width to microseconds, pulse classing,
// wave pairing, byte assembly and block ends. Depends on tpbd_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o  | action_i, pulse_ticks_i
//  out     | output    | out_valid_o / out_stall_i| result_kind_o, result_value_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A pulse sample is taken in ST_IDLE, then passes TICK_BITS steps of the
// restoring divider (one quotient bit each), a rounding step and a step that
// classifies and commits; no new item is taken until that commit. The skipped
// first pulse only sets a flag in ST_IDLE, and an end of stream goes straight
// to the commit step. Reset clears all control and decode state at once; there
// is no clearing pass. A result waits in the output register while the next
// item is taken; commit of a later result holds until that register is free.
module tape_pulse_to_byte_block_decoder #(
  parameter int unsigned TICK_BITS = tpbd_pkg::TickBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input item channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [TICK_BITS-1:0]           pulse_ticks_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tpbd_pkg::KindW-1:0]     result_kind_o,
  output logic [tpbd_pkg::ValueW-1:0]    result_value_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tpbd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tpbd_pkg::*;

  localparam int unsigned CntW = $clog2(TICK_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [DivW-1:0] tpus_q;
  logic [UsW-1:0]  short_min_q, short_max_q, long_limit_q;

  // Item and divider datapath
  logic                 act_q;
  logic [TICK_BITS-1:0] dq_q;      // dividend shifting out, quotient shifting in
  logic [DivW:0]        rem_q;
  logic [DivW-1:0]      div_q;
  logic [CntW-1:0]      cnt_q;
  logic [TICK_BITS-1:0] len_q;

  // Decode state
  logic       first_skip_q;
  pulse_cls_e prev_cls_q;
  logic [1:0] phase_q;
  logic [1:0] run_q;
  logic [2:0] bitc_q;
  logic [7:0] shift_q;
  logic [UsW-1:0] count_q;
  logic       any_q;

  // Output register
  logic               out_valid_q;
  logic [KindW-1:0]   kind_q;
  logic [ValueW-1:0]  value_q;

  // Next decode state from the commit logic
  pulse_cls_e prev_cls_d;
  logic [1:0] phase_d, run_d;
  logic [2:0] bitc_d;
  logic [7:0] shift_d;
  logic [UsW-1:0] count_d;
  logic       any_d, first_skip_d;
  logic       emit;
  logic [KindW-1:0]  kind_d;
  logic [ValueW-1:0] value_d;

  logic [DivW-1:0] div_eff;
  logic [DivW:0]   rem_sh, rem_sub;
  logic            qbit;
  logic            round_up;
  pulse_cls_e      cls;
  logic            commit;
  logic            in_xfer;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign result_value_o = value_q;

  // Treat a zero divisor as one
  assign div_eff = (tpus_q == '0) ? DivW'(1) : tpus_q;

  // One restoring divide step
  assign rem_sh  = {rem_q[DivW-1:0], dq_q[TICK_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign qbit    = (rem_sh >= {1'b0, div_q});

  // Round half up: remainder plus half divisor reaching the divisor
  assign round_up = ((rem_q + {2'b00, div_q[DivW-1:1]}) >= {1'b0, div_q});

  // Class the rounded width
  always_comb begin
    if ((len_q >= TICK_BITS'(short_min_q)) && (len_q <= TICK_BITS'(short_max_q))) begin
      cls = CLS_SHORT;
    end else if ((len_q > TICK_BITS'(short_max_q)) && (len_q < TICK_BITS'(long_limit_q))) begin
      cls = CLS_LONG;
    end else begin
      cls = CLS_PAUSE;
    end
  end

  // Work out the decode update and the result of the current item
  always_comb begin
    prev_cls_d   = prev_cls_q;
    phase_d      = phase_q;
    run_d        = run_q;
    bitc_d       = bitc_q;
    shift_d      = shift_q;
    count_d      = count_q;
    any_d        = any_q;
    first_skip_d = first_skip_q;
    emit         = 1'b0;
    kind_d       = KindByte;
    value_d      = '0;
    if (act_q == ActEnd) begin
      // Close the stream and return to reset values
      if (count_q != '0) begin
        emit    = 1'b1;
        kind_d  = KindBlock;
        value_d = count_q;
      end else if (!any_q) begin
        emit    = 1'b1;
        kind_d  = KindEmpty;
      end
      prev_cls_d   = CLS_PAUSE;
      phase_d      = PhaseNone;
      run_d        = '0;
      bitc_d       = '0;
      shift_d      = '0;
      count_d      = '0;
      any_d        = 1'b0;
      first_skip_d = 1'b0;
    end else if (cls == CLS_PAUSE) begin
      // Close the block; keep the partial shift byte
      prev_cls_d = cls;
      phase_d    = PhaseNone;
      run_d      = '0;
      bitc_d     = '0;
      count_d    = '0;
      if (count_q != '0) begin
        emit    = 1'b1;
        kind_d  = KindBlock;
        value_d = count_q;
      end
    end else begin
      prev_cls_d = cls;
      if (phase_q != PhaseOdd) begin
        phase_d = PhaseOdd;
      end else begin
        phase_d = PhaseEven;
        if (prev_cls_q != cls) begin
          run_d = '0;
        end else begin
          run_d = (run_q < RunFull) ? run_q + 2'd1 : run_q;
          if (run_d == RunFull) begin
            // Shift in the wave bit, MSB first
            shift_d = {shift_q[6:0], (cls == CLS_LONG)} & ByteMask;
            if (bitc_q == 3'd7) begin
              bitc_d  = '0;
              count_d = (count_q != CountMax) ? count_q + UsW'(1) : count_q;
              any_d   = 1'b1;
              emit    = 1'b1;
              kind_d  = KindByte;
              value_d = ValueW'(shift_d);
            end else begin
              bitc_d = bitc_q + 3'd1;
            end
          end
        end
      end
    end
  end

  // Commit once the output register can take any result
  assign commit = (state_q == ST_FIN) && (!emit || !out_valid_q || !out_stall_i);

  // Configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpus_q       <= TicksPerUsRst;
      short_min_q  <= ShortMinRst;
      short_max_q  <= ShortMaxRst;
      long_limit_q <= LongLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTicksPerUs: tpus_q       <= cfg_data_i[DivW-1:0];
        CfgShortMin:   short_min_q  <= cfg_data_i;
        CfgShortMax:   short_max_q  <= cfg_data_i;
        CfgLongLimit:  long_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          act_q <= action_i;
          dq_q  <= pulse_ticks_i;
          rem_q <= '0;
          div_q <= div_eff;
          cnt_q <= CntW'(TICK_BITS - 1);
        end
      end
      ST_DIV: begin
        rem_q <= qbit ? rem_sub : rem_sh;
        dq_q  <= {dq_q[TICK_BITS-2:0], qbit};
        cnt_q <= cnt_q - CntW'(1);
      end
      ST_ROUND: begin
        len_q <= dq_q + TICK_BITS'(round_up);
      end
      default: ;
    endcase
  end

  // Sequencer, decode state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_skip_q <= 1'b0;
      prev_cls_q   <= CLS_PAUSE;
      phase_q      <= PhaseNone;
      run_q        <= '0;
      bitc_q       <= '0;
      shift_q      <= '0;
      count_q      <= '0;
      any_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      kind_q       <= KindByte;
      value_q      <= '0;
    end else begin
      // Drop the result once it is taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && !(commit && emit)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (action_i == ActEnd) begin
              state_q <= ST_FIN;
            end else if (!first_skip_q) begin
              first_skip_q <= 1'b1;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (commit) begin
            state_q      <= ST_IDLE;
            first_skip_q <= first_skip_d;
            prev_cls_q   <= prev_cls_d;
            phase_q      <= phase_d;
            run_q        <= run_d;
            bitc_q       <= bitc_d;
            shift_q      <= shift_d;
            count_q      <= count_d;
            any_q        <= any_d;
            if (emit) begin
              out_valid_q <= 1'b1;
              kind_q      <= kind_d;
              value_q     <= value_d;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider remainder stays below the latched divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < {1'b0, div_q}))
    else $error("divider remainder not below divisor");

  // A pending result is never overwritten by a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && emit && out_valid_q && out_stall_i) |=>
      (state_q == ST_FIN && out_valid_q && $stable(value_q) && $stable(kind_q)))
    else $error("result commit while output register full");

  // Phase never takes the unused code, run never passes saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != 2'd3) && (run_q <= RunFull))
    else $error("wave phase or run out of range");

  // A byte result always follows a completed byte with bit counter cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && emit && kind_d == KindByte) |=> (bitc_q == '0 && any_q && count_q != '0))
    else $error("byte emitted without byte bookkeeping");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the tape pulse to byte block decoder.
// Drives pulse and end-of-stream transfers, tracks the decode in a local predictor
// and checks every result transfer in order. Depends on tpbd_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpbd_pkg::*;

  localparam int unsigned TICK_BITS     = TickBitsDef;
  localparam int unsigned SETTLE_CYCLES = 2 * (TICK_BITS + 3) + 16;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam longint     TIMEOUT_NS     = 64'd6_000_000;

  // Directed widths under the reset settings: 250 us, 450 us and 1000 us
  localparam logic [TICK_BITS-1:0] ShortTicks = 40'd4000;
  localparam logic [TICK_BITS-1:0] LongTicks  = 40'd7200;
  localparam logic [TICK_BITS-1:0] PauseTicks = 40'd16000;
  localparam logic [7:0]           DirByte    = 8'ha5;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;
  typedef enum logic [1:0] {STALL_OFF, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
  } tape_result_t;

  typedef struct {
    logic                 act;
    logic [TICK_BITS-1:0] ticks;
    check_e               chk;
    logic [KindW-1:0]     kind;
    logic [ValueW-1:0]    value;
  } stim_row_t;

  typedef struct {
    logic [CfgDataW-1:0] tpu;
    logic [CfgDataW-1:0] smin;
    logic [CfgDataW-1:0] smax;
    logic [CfgDataW-1:0] llim;
  } cfg_set_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic                 action_i      = ActPulse;
  logic [TICK_BITS-1:0] pulse_ticks_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [KindW-1:0]     result_kind_o;
  logic [ValueW-1:0]    result_value_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  // Predictor copy of the registers
  logic [DivW-1:0] cfg_tpu        = TicksPerUsRst;
  logic [UsW-1:0]  cfg_short_min  = ShortMinRst;
  logic [UsW-1:0]  cfg_short_max  = ShortMaxRst;
  logic [UsW-1:0]  cfg_long_limit = LongLimitRst;

  // Predictor copy of the decode state
  bit              dec_seen_first = 1'b0;
  pulse_cls_e      dec_prev_cls   = CLS_PAUSE;
  logic [1:0]      dec_phase      = PhaseNone;
  logic [1:0]      dec_run        = '0;
  logic [2:0]      dec_bits       = '0;
  logic [7:0]      dec_shift      = '0;
  logic [UsW-1:0]  dec_count      = '0;
  bit              dec_any_byte   = 1'b0;

  tape_result_t awaited_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left     = 0;
  stall_mode_e  stall_mode     = STALL_OFF;
  int unsigned  stall_left     = 0;

  tape_pulse_to_byte_block_decoder #(
    .TICK_BITS(TICK_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .pulse_ticks_i (pulse_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .result_value_o(result_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode one accepted item; return whether it yields a result
  function automatic bit decode_item(input logic act, input logic [TICK_BITS-1:0] ticks,
                                     output tape_result_t res);
    logic [63:0] div;
    logic [63:0] quo;
    logic [63:0] rem;
    pulse_cls_e  cls;
    pulse_cls_e  prev;
    bit          emits;
    res   = '{KindByte, '0};
    emits = 1'b0;
    // End of stream: close the pending block or flag an empty stream, then start over
    if (act == ActEnd) begin
      if (dec_count != '0) begin
        res   = '{KindBlock, dec_count};
        emits = 1'b1;
      end else if (!dec_any_byte) begin
        res   = '{KindEmpty, '0};
        emits = 1'b1;
      end
      dec_seen_first = 1'b0;
      dec_prev_cls   = CLS_PAUSE;
      dec_phase      = PhaseNone;
      dec_run        = '0;
      dec_bits       = '0;
      dec_shift      = '0;
      dec_count      = '0;
      dec_any_byte   = 1'b0;
      return emits;
    end
    // Drop the first pulse after a fresh start
    if (!dec_seen_first) begin
      dec_seen_first = 1'b1;
      return 1'b0;
    end
    // Convert to rounded microseconds; a zero divisor acts as one
    div = (cfg_tpu == '0) ? 64'd1 : 64'(cfg_tpu);
    quo = 64'(ticks) / div;
    rem = 64'(ticks) % div;
    if (rem + div / 2 >= div) quo++;
    if (quo >= 64'(cfg_short_min) && quo <= 64'(cfg_short_max)) cls = CLS_SHORT;
    else if (quo > 64'(cfg_short_max) && quo < 64'(cfg_long_limit)) cls = CLS_LONG;
    else cls = CLS_PAUSE;
    prev         = dec_prev_cls;
    dec_prev_cls = cls;
    // Pause: close the block, keep the shift byte
    if (cls == CLS_PAUSE) begin
      if (dec_count != '0) begin
        res   = '{KindBlock, dec_count};
        emits = 1'b1;
      end
      dec_phase = PhaseNone;
      dec_run   = '0;
      dec_count = '0;
      dec_bits  = '0;
      return emits;
    end
    // Pair on every second data pulse
    if (dec_phase != PhaseOdd) begin
      dec_phase = PhaseOdd;
      return 1'b0;
    end
    dec_phase = PhaseEven;
    if (prev != cls) begin
      dec_run = '0;
      return 1'b0;
    end
    // Drop the first good wave after a pause or an error wave
    if (dec_run != RunFull) dec_run++;
    if (dec_run != RunFull) return 1'b0;
    dec_shift = {dec_shift[6:0], (cls == CLS_LONG)};
    if (dec_bits == 3'd7) begin
      dec_bits     = '0;
      dec_any_byte = 1'b1;
      if (dec_count != CountMax) dec_count++;
      res = '{KindByte, ValueW'(dec_shift)};
      return 1'b1;
    end
    dec_bits++;
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Present one item, wait for its transfer, then maybe end the burst with a gap
  task automatic send_item(input logic act, input logic [TICK_BITS-1:0] ticks,
                           input check_e chk = CHK_MODEL,
                           input logic [KindW-1:0] kind = KindByte,
                           input logic [ValueW-1:0] value = '0);
    tape_result_t predicted;
    tape_result_t typed;
    bit           emits;
    int unsigned  gap;
    in_valid_i    <= 1'b1;
    action_i      <= act;
    pulse_ticks_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
    emits = decode_item(act, ticks, predicted);
    typed = '{kind, value};
    case (chk)
      CHK_MODEL: if (emits) awaited_results.push_back(predicted);
      CHK_ONE:   awaited_results.push_back(typed);
      default:   ;
    endcase
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Send one pulse whose rounded width lies in the band of the given class
  task automatic send_pulse_of(input pulse_cls_e cls);
    int unsigned lo;
    int unsigned hi;
    int unsigned us;
    logic [63:0] div;
    logic [63:0] ticks;
    case (cls)
      CLS_SHORT: begin
        lo = 32'(cfg_short_min);
        hi = 32'(cfg_short_max);
      end
      CLS_LONG: begin
        lo = 32'(cfg_short_max) + 1;
        hi = (cfg_long_limit == '0) ? 0 : 32'(cfg_long_limit) - 1;
      end
      default: begin
        if (cfg_short_min != '0 && $urandom_range(0, 3) == 0) begin
          lo = 0;
          hi = 32'(cfg_short_min) - 1;
        end else begin
          lo = 32'(cfg_long_limit);
          hi = lo + 3000;
        end
      end
    endcase
    if (lo > hi) begin
      us = $urandom_range(0, 70000);
    end else begin
      case ($urandom_range(0, 7))
        0:       us = lo;
        1:       us = hi;
        default: us = $urandom_range(lo, hi);
      endcase
    end
    // Jitter within the rounding window so the width still rounds to us
    div   = (cfg_tpu == '0) ? 64'd1 : 64'(cfg_tpu);
    ticks = 64'(us) * div + 64'($urandom_range(0, int'(div) - 1));
    ticks = (ticks >= div / 2) ? ticks - div / 2 : '0;
    send_item(ActPulse, ticks[TICK_BITS-1:0]);
  endtask

  // Hold a register write until the transfer, then update the predictor copy
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTicksPerUs: cfg_tpu        = data[DivW-1:0];
      CfgShortMin:   cfg_short_min  = data[UsW-1:0];
      CfgShortMax:   cfg_short_max  = data[UsW-1:0];
      CfgLongLimit:  cfg_long_limit = data[UsW-1:0];
      default:       ;
    endcase
  endtask

  // Wait until every result is in and the last item has left the divider
  task automatic drain_decoder();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result stall pattern: switch between a few modes every so often
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= STALL_OFF;
      stall_left  <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_left <= $urandom_range(32, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_OFF:   out_stall_i <= 1'b0;
        STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) != 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Compare each result transfer with the oldest awaited one
  always @(posedge clk_i) begin
    tape_result_t got;
    tape_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{result_kind_o, result_value_o};
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unawaited result kind %0d value %0d", got.kind, got.value));
      end else begin
        want = awaited_results.pop_front();
        if (got.kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.value !== want.value)
          flag_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
      end
    end
  end

  initial begin : stimulus
    stim_row_t            rows[$];
    cfg_set_t             settings[$];
    logic [TICK_BITS-1:0] wave_ticks;
    int unsigned          sent;
    int unsigned          pick;
    pulse_cls_e           wave_cls;

    // Directed rows under the reset settings
    rows.push_back('{ActEnd,   '0, CHK_ONE,  KindEmpty, 16'd0});  // empty stream
    rows.push_back('{ActPulse, '0, CHK_NONE, KindByte,  16'd0});  // skipped first pulse
    rows.push_back('{ActPulse, '1, CHK_NONE, KindByte,  16'd0});  // widest: pause, no bytes
    rows.push_back('{ActPulse, '0, CHK_NONE, KindByte,  16'd0});  // too short: pause
    rows.push_back('{ActPulse, ShortTicks, CHK_MODEL, KindByte, 16'd0});  // error wave
    rows.push_back('{ActPulse, LongTicks,  CHK_MODEL, KindByte, 16'd0});
    rows.push_back('{ActPulse, LongTicks,  CHK_MODEL, KindByte, 16'd0});  // dropped wave
    rows.push_back('{ActPulse, LongTicks,  CHK_MODEL, KindByte, 16'd0});
    for (int b = 7; b >= 0; b--) begin
      wave_ticks = DirByte[b] ? LongTicks : ShortTicks;
      rows.push_back('{ActPulse, wave_ticks, CHK_MODEL, KindByte, 16'd0});
      if (b == 0) rows.push_back('{ActPulse, wave_ticks, CHK_ONE, KindByte, ValueW'(DirByte)});
      else rows.push_back('{ActPulse, wave_ticks, CHK_MODEL, KindByte, 16'd0});
    end
    rows.push_back('{ActPulse, PauseTicks, CHK_ONE, KindBlock, 16'd1});  // one-byte block
    rows.push_back('{ActEnd,   '0, CHK_NONE, KindByte, 16'd0});  // nothing pending

    // Register sets; the upper data bits of the divisor are masked off
    settings.push_back('{16'hffff, 16'd150, 16'd360,   16'd550});    // divisor 1023
    settings.push_back('{16'd1,    16'd0,   16'd3,     16'd7});
    settings.push_back('{16'h0400, 16'd100, 16'd200,   16'd300});    // divisor 0
    settings.push_back('{16'd37,   16'd0,   16'd65534, 16'hffff});
    settings.push_back('{16'd7,    16'd300, 16'd200,   16'd100});    // inverted bands
    settings.push_back('{16'd16,   16'd150, 16'd360,   16'd550});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].act, rows[i].ticks, rows[i].chk, rows[i].kind,
                                rows[i].value);

    foreach (settings[p]) begin
      drain_decoder();
      write_reg(CfgTicksPerUs, settings[p].tpu);
      write_reg(CfgShortMin,   settings[p].smin);
      write_reg(CfgShortMax,   settings[p].smax);
      write_reg(CfgLongLimit,  settings[p].llim);
      // Unused index: the write must be dropped
      write_reg(CfgIdxW'($urandom_range(int'(CfgLongLimit) + 1, (1 << CfgIdxW) - 1)),
                CfgDataW'($urandom));
      cfg_valid_i <= 1'b0;

      // Mostly well-formed waves, with error waves, pauses, noise and stream ends
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
          if ($urandom_range(0, 1) != 0) wave_cls = CLS_LONG;
          else wave_cls = CLS_SHORT;
          send_pulse_of(wave_cls);
          send_pulse_of(wave_cls);
          sent += 2;
        end else if (pick < 90) begin
          if ($urandom_range(0, 1) != 0) begin
            send_pulse_of(CLS_SHORT);
            send_pulse_of(CLS_LONG);
          end else begin
            send_pulse_of(CLS_LONG);
            send_pulse_of(CLS_SHORT);
          end
          sent += 2;
        end else if (pick < 94) begin
          send_pulse_of(CLS_PAUSE);
          sent++;
        end else if (pick < 98) begin
          // Lone pulse shifts the pairing; raw widths cover every tick bit
          if ($urandom_range(0, 1) != 0) send_pulse_of(wave_cls);
          else send_item(ActPulse, TICK_BITS'({$urandom, $urandom}));
          sent++;
        end else begin
          send_item(ActEnd, TICK_BITS'({$urandom, $urandom}));
          sent++;
        end
      end
    end

    drain_decoder();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
design/tpbd_pkg.sv
design/tape_pulse_to_byte_block_decoder.sv
verif/tb.sv
